[design/mfr_pkg.sv]
// Shared types and constants for the 3x3 RGB median filter.
// Holds the request, result and line store entry layouts and the register codes.
// No dependencies.
package mfr_pkg;

   localparam int PIX_W = 8;
   localparam int CH_NUM = 3;
   localparam int KSIZE = 3;
   localparam int CELL_NUM = KSIZE * KSIZE;

   localparam int WIDTH_REG_W = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int ROW_W = 13;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 11'd512;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd512;
   localparam logic [HEIGHT_REG_W-1:0] MAX_HEIGHT = 13'd4096;

   typedef logic [PIX_W-1:0] sample_type;
   typedef logic [CH_NUM*PIX_W-1:0] pixel_type;
   typedef logic [CELL_NUM-1:0][PIX_W-1:0] cell_set_type;

   typedef struct packed {
      sample_type pix_ch0;
      sample_type pix_ch1;
      sample_type pix_ch2;
      logic       flush;
   } req_type;

   typedef struct packed {
      sample_type med_ch0;
      sample_type med_ch1;
      sample_type med_ch2;
      logic       row_end;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_type;

endpackage

[design/median_filter_3x3_rgb.sv]
// Streaming 3x3 median filter over three 8-bit colour channels, zero padded.
// Top level: input register, window and position control, result register.
// Depends on mfr_pkg, mfr_line_store and mfr_median9.
//
//   channel   direction   handshake            carries
//   req       in          req_valid/req_stall  one pixel or a flush request
//   rsp       out         rsp_valid/rsp_stall  three channel medians and row/frame ends
//   csr       in          csr_valid/csr_ready  register index and write data
//
// One request is taken every cycle while req_stall is low; the result it releases is registered.
// The result for a pixel is released by the request one row and one column later, and the
// result for the last pixel of a row by the first request two rows later.
// After reset the line store is swept to zero, one entry after another, while req_stall is high.
// A stalled result register holds its result and the input register still takes one request.
// The csr channel is always ready.
module median_filter_3x3_rgb #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mfr_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mfr_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mfr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mfr_pkg::CSR_DATA_W-1:0]      csr_data
);
   import mfr_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CMPW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;

   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [XW-1:0]           x_ff;
   logic [ROW_W-1:0]        y_ff;
   pixel_type               win_ff [KSIZE][KSIZE];
   logic                    in_valid_ff;
   logic                    in_valid_in;
   req_type                 in_data_ff;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   rsp_type                 out_data_ff;
   rsp_type                 out_data_in;

   logic                    clear_busy;
   line_type                line_rd;
   line_type                line_wr;
   logic                    line_we;
   logic [XW-1:0]           line_rd_addr;

   logic                    out_free;
   logic                    advance;
   logic                    accept;

   logic [CMPW-1:0]         width_ext;
   logic [WW-1:0]           w_eff;
   logic [ROW_W-1:0]        h_eff;
   logic [ROW_W:0]          h_plus;
   logic                    pos_wrap;
   logic [XW-1:0]           x_cur;
   logic [ROW_W-1:0]        y_cur;
   logic [XW-1:0]           x_next;
   logic [ROW_W-1:0]        y_next;
   logic [WW:0]             x_plus;
   logic                    active;
   logic                    last_item;
   logic                    pending;
   logic                    normal;
   logic                    produce;
   logic                    left_on;
   pixel_type               sample;
   pixel_type               new_col [KSIZE];
   cell_set_type            cells [CH_NUM];
   sample_type              med [CH_NUM];

   mfr_line_store #(
      .DEPTH(MAX_WIDTH)
   ) u_line_store (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (line_we),
      .wr_addr   (x_cur),
      .wr_data   (line_wr),
      .rd_addr   (line_rd_addr),
      .rd_data   (line_rd),
      .clear_busy(clear_busy)
   );

   for (genvar ch = 0; ch < CH_NUM; ch++) begin : g_med
      mfr_median9 u_median9 (
         .cells (cells[ch]),
         .median(med[ch])
      );
   end

   // Handshake and flow between the input and result registers.
   always_comb begin
      out_free = !out_valid_ff || !rsp_stall;
      advance = in_valid_ff && out_free;
      req_stall = clear_busy || (in_valid_ff && !out_free);
      accept = req_valid && !req_stall;
      in_valid_in = accept || (in_valid_ff && !advance);
      out_valid_in = advance ? produce : (out_valid_ff && rsp_stall);
   end

   // Effective frame geometry and position of the request in the input register.
   always_comb begin
      width_ext = CMPW'(width_ff);
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (width_ext > CMPW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ext);
      end

      if (height_ff == '0) begin
         h_eff = ROW_W'(1);
      end else if (height_ff > MAX_HEIGHT) begin
         h_eff = MAX_HEIGHT;
      end else begin
         h_eff = height_ff;
      end
      h_plus = (ROW_W + 1)'(h_eff) + (ROW_W + 1)'(1);

      pos_wrap = (WW'(x_ff) >= w_eff) || ((ROW_W + 1)'(y_ff) > h_plus)
                 || (((ROW_W + 1)'(y_ff) == h_plus) && (x_ff != '0));
      x_cur = pos_wrap ? '0 : x_ff;
      y_cur = pos_wrap ? '0 : y_ff;

      active = (y_cur <= h_eff);
      last_item = ((ROW_W + 1)'(y_cur) >= h_plus);
      x_plus = (WW + 1)'(x_cur) + (WW + 1)'(1);

      if (last_item) begin
         x_next = '0;
         y_next = '0;
      end else if (x_plus >= (WW + 1)'(w_eff)) begin
         x_next = '0;
         y_next = y_cur + ROW_W'(1);
      end else begin
         x_next = x_plus[XW-1:0];
         y_next = y_cur;
      end

      line_rd_addr = advance ? x_next : x_cur;
   end

   // Window column entering this cycle and the cells fed to the median networks.
   always_comb begin
      if (in_data_ff.flush || (y_cur >= h_eff)) begin
         sample = '0;
      end else begin
         sample = {in_data_ff.pix_ch2, in_data_ff.pix_ch1, in_data_ff.pix_ch0};
      end
      new_col[0] = (y_cur >= ROW_W'(2)) ? line_rd.upper : '0;
      new_col[1] = (y_cur != '0) ? line_rd.middle : '0;
      new_col[2] = sample;

      line_we = advance && active;
      line_wr.upper = new_col[1];
      line_wr.middle = sample;

      pending = (x_cur == '0) && (y_cur >= ROW_W'(2));
      normal = active && (x_cur != '0) && (y_cur != '0);
      produce = pending || normal;
      left_on = pending ? (w_eff >= WW'(2)) : (x_cur >= XW'(2));

      for (int ch = 0; ch < CH_NUM; ch++) begin
         for (int r = 0; r < KSIZE; r++) begin
            cells[ch][r*KSIZE]     = left_on ? win_ff[r][1][ch*PIX_W +: PIX_W] : '0;
            cells[ch][r*KSIZE + 1] = win_ff[r][2][ch*PIX_W +: PIX_W];
            cells[ch][r*KSIZE + 2] = pending ? '0 : new_col[r][ch*PIX_W +: PIX_W];
         end
      end

      out_data_in.med_ch0 = med[0];
      out_data_in.med_ch1 = med[1];
      out_data_in.med_ch2 = med[2];
      out_data_in.row_end = pending;
      out_data_in.frame_end = pending && ((ROW_W + 1)'(y_cur) == h_plus);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: begin
               width_ff <= csr_data[WIDTH_REG_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
               height_ff <= csr_data[HEIGHT_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int r = 0; r < KSIZE; r++) begin
            for (int c = 0; c < KSIZE; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            x_ff <= x_next;
            y_ff <= y_next;
         end
         if (line_we) begin
            for (int r = 0; r < KSIZE; r++) begin
               win_ff[r][0] <= win_ff[r][1];
               win_ff[r][1] <= win_ff[r][2];
               win_ff[r][2] <= new_col[r];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance && produce) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;
   assign csr_ready = 1'b1;

   a_clear_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> req_stall)
      else $error("Request accepted while the line store is being cleared.");

   a_frame_end_ends_row: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.frame_end) |-> out_data_ff.row_end)
      else $error("Frame end flagged on a result that does not end a row.");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (advance && produce) |=> (out_valid_ff && (out_data_ff.row_end == $past(pending))))
      else $error("Processed request did not load its result.");

endmodule

[design/mfr_line_store.sv]
// Line store holding the two rows above the incoming one, one entry per column.
// Cleared to zero by a sweep after reset; read data is registered and bypassed.
// Depends on mfr_pkg.
module mfr_line_store #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  mfr_pkg::line_type        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output mfr_pkg::line_type        rd_data,
   output logic                     clear_busy
);
   import mfr_pkg::*;

   localparam int AW = $clog2(DEPTH);

   line_type        line_mem [DEPTH];
   line_type        rd_data_ff;
   logic [AW-1:0]   clear_addr_ff;
   logic [AW-1:0]   clear_addr_in;
   logic            clear_busy_ff;
   logic            clear_busy_in;
   logic            mem_we;
   logic [AW-1:0]   mem_addr;
   line_type        mem_wdata;

   always_comb begin
      clear_addr_in = clear_addr_ff + AW'(1);
      clear_busy_in = clear_busy_ff && (clear_addr_ff != AW'(DEPTH - 1));
      mem_we = clear_busy_ff || wr_en;
      mem_addr = clear_busy_ff ? clear_addr_ff : wr_addr;
      mem_wdata = clear_busy_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_busy_ff) begin
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_addr] <= mem_wdata;
      end
      if (mem_we && (mem_addr == rd_addr)) begin
         rd_data_ff <= mem_wdata;
      end else begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign clear_busy = clear_busy_ff;

endmodule

[design/mfr_median9.sv]
// Median of nine 8-bit samples through a fixed compare-exchange network.
// Purely combinational; one instance serves one colour channel.
// Depends on mfr_pkg.
module mfr_median9 (
   input  mfr_pkg::cell_set_type cells,
   output mfr_pkg::sample_type   median
);
   import mfr_pkg::*;

   function automatic logic [2*PIX_W-1:0] sort_pair(input sample_type a, input sample_type b);
      if (a > b) begin
         return {b, a};
      end else begin
         return {a, b};
      end
   endfunction

   sample_type p [CELL_NUM];

   always_comb begin
      for (int i = 0; i < CELL_NUM; i++) begin
         p[i] = cells[i];
      end
      {p[1], p[2]} = sort_pair(p[1], p[2]);
      {p[4], p[5]} = sort_pair(p[4], p[5]);
      {p[7], p[8]} = sort_pair(p[7], p[8]);
      {p[0], p[1]} = sort_pair(p[0], p[1]);
      {p[3], p[4]} = sort_pair(p[3], p[4]);
      {p[6], p[7]} = sort_pair(p[6], p[7]);
      {p[1], p[2]} = sort_pair(p[1], p[2]);
      {p[4], p[5]} = sort_pair(p[4], p[5]);
      {p[7], p[8]} = sort_pair(p[7], p[8]);
      {p[0], p[3]} = sort_pair(p[0], p[3]);
      {p[5], p[8]} = sort_pair(p[5], p[8]);
      {p[4], p[7]} = sort_pair(p[4], p[7]);
      {p[3], p[6]} = sort_pair(p[3], p[6]);
      {p[1], p[4]} = sort_pair(p[1], p[4]);
      {p[2], p[5]} = sort_pair(p[2], p[5]);
      {p[4], p[7]} = sort_pair(p[4], p[7]);
      {p[4], p[2]} = sort_pair(p[4], p[2]);
      {p[6], p[4]} = sort_pair(p[6], p[4]);
      {p[4], p[2]} = sort_pair(p[4], p[2]);
   end

   assign median = p[4];

endmodule

[tb/tb_median_filter_3x3_rgb.sv]
// Testbench for the streaming 3x3 RGB median filter, checked result by result
// against a behavioural predictor of the window and line stores kept here.
// Depends on mfr_pkg and median_filter_3x3_rgb.
`timescale 1ns / 1ps

module tb_median_filter_3x3_rgb;
   import mfr_pkg::*;

   localparam int LINE_DEPTH = 1024;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 600000;
   localparam int IDLE_PERCENT = 17;
   localparam int RANDOM_REQUESTS = 900;
   localparam int EXTREME_REQUESTS = 40;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED = 4'd15;

   typedef logic [CELL_NUM-1:0][CH_NUM*PIX_W-1:0] window_cells_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   req_type                pixel_backlog[$];
   rsp_type                expected_medians[$];
   rsp_type                want;

   logic [WIDTH_REG_W-1:0]  cfg_width = WIDTH_RESET;
   logic [HEIGHT_REG_W-1:0] cfg_height = HEIGHT_RESET;
   pixel_type               top_line[LINE_DEPTH];
   pixel_type               mid_line[LINE_DEPTH];
   pixel_type               win[KSIZE][KSIZE];
   int                      col_at = 0;
   int                      row_at = 0;

   int   mismatches = 0;
   int   cycles = 0;
   int   hold_left = 0;
   int   queued_total = 0;
   logic steady = 1'b0;
   logic hold_wanted = 1'b0;
   logic hold_done = 1'b0;

   median_filter_3x3_rgb #(
      .MAX_WIDTH(LINE_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic sample_type median_of(window_cells_type cells, int ch);
      cell_set_type v;
      sample_type   t;
      for (int i = 0; i < CELL_NUM; i++) v[i] = cells[i][ch*PIX_W +: PIX_W];
      for (int i = 0; i < CELL_NUM - 1; i++) begin
         for (int j = 0; j < CELL_NUM - 1 - i; j++) begin
            if (v[j] > v[j+1]) begin
               t = v[j];
               v[j] = v[j+1];
               v[j+1] = t;
            end
         end
      end
      return v[CELL_NUM/2];
   endfunction

   function automatic void note_medians(window_cells_type cells, logic row_end,
                                        logic frame_end);
      rsp_type m;
      m.med_ch0 = median_of(cells, 0);
      m.med_ch1 = median_of(cells, 1);
      m.med_ch2 = median_of(cells, 2);
      m.row_end = row_end;
      m.frame_end = frame_end;
      expected_medians.push_back(m);
   endfunction

   // Advances the window and line stores by one accepted request and notes the
   // median it releases, if any.
   task automatic filter_pixel(input req_type item);
      int               w;
      int               h;
      int               x;
      int               y;
      pixel_type        sample;
      pixel_type        top;
      pixel_type        mid;
      window_cells_type cells;
      w = cfg_width;
      h = cfg_height;
      if (w < 1) w = 1;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      x = col_at;
      y = row_at;
      if (x >= w || y > h + 1 || (y == h + 1 && x != 0)) begin
         x = 0;
         y = 0;
      end
      if (item.flush || y >= h) sample = '0;
      else sample = {item.pix_ch2, item.pix_ch1, item.pix_ch0};

      // The last pixel of row y-2 is still waiting in the window.
      if (x == 0 && y >= 2) begin
         for (int r = 0; r < KSIZE; r++) begin
            cells[r*KSIZE] = (w >= 2) ? win[r][1] : '0;
            cells[r*KSIZE+1] = win[r][2];
            cells[r*KSIZE+2] = '0;
         end
         note_medians(cells, 1'b1, y == h + 1);
      end

      if (y <= h) begin
         top = (y >= 2) ? top_line[x] : '0;
         mid = (y >= 1) ? mid_line[x] : '0;
         top_line[x] = mid;
         mid_line[x] = sample;
         for (int r = 0; r < KSIZE; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
         end
         win[0][2] = top;
         win[1][2] = mid;
         win[2][2] = sample;
         if (x >= 1 && y >= 1) begin
            for (int r = 0; r < KSIZE; r++) begin
               cells[r*KSIZE] = (x >= 2) ? win[r][0] : '0;
               cells[r*KSIZE+1] = win[r][1];
               cells[r*KSIZE+2] = win[r][2];
            end
            note_medians(cells, 1'b0, 1'b0);
         end
      end

      if (y >= h + 1) begin
         x = 0;
         y = 0;
      end else if (x + 1 >= w) begin
         x = 0;
         y++;
      end else begin
         x++;
      end
      col_at = x;
      row_at = y;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) filter_pixel(req_data);
         if (!req_valid || !req_stall) begin
            if (pixel_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
               req_valid <= 1'b1;
               req_data <= pixel_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_medians.size() == 0) begin
               $error("result with no request waiting for it");
               mismatches++;
            end else begin
               want = expected_medians.pop_front();
               if (rsp_data.med_ch0 !== want.med_ch0) begin
                  $error("med_ch0 expected %0d actual %0d", want.med_ch0, rsp_data.med_ch0);
                  mismatches++;
               end
               if (rsp_data.med_ch1 !== want.med_ch1) begin
                  $error("med_ch1 expected %0d actual %0d", want.med_ch1, rsp_data.med_ch1);
                  mismatches++;
               end
               if (rsp_data.med_ch2 !== want.med_ch2) begin
                  $error("med_ch2 expected %0d actual %0d", want.med_ch2, rsp_data.med_ch2);
                  mismatches++;
               end
               if (rsp_data.row_end !== want.row_end) begin
                  $error("row_end expected %0d actual %0d", want.row_end, rsp_data.row_end);
                  mismatches++;
               end
               if (rsp_data.frame_end !== want.frame_end) begin
                  $error("frame_end expected %0d actual %0d", want.frame_end,
                         rsp_data.frame_end);
                  mismatches++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left--;
         end else if (hold_wanted && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done <= 1'b1;
         end
         rsp_stall <= (hold_left != 0) || (!steady && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   function automatic sample_type rand_sample();
      int pick = $urandom_range(9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return sample_type'($urandom_range(255));
   endfunction

   function automatic void queue_pixel(sample_type c0, sample_type c1, sample_type c2,
                                       logic flush);
      req_type item;
      item.pix_ch0 = c0;
      item.pix_ch1 = c1;
      item.pix_ch2 = c2;
      item.flush = flush;
      pixel_backlog.push_back(item);
      queued_total++;
   endfunction

   // One frame of random pixels followed by its padding row and the extra item.
   function automatic void queue_frame(int w, int h);
      for (int i = 0; i < w * h; i++)
         queue_pixel(rand_sample(), rand_sample(), rand_sample(), $urandom_range(99) < 4);
      for (int i = 0; i <= w; i++)
         queue_pixel(sample_type'($urandom), sample_type'($urandom), sample_type'($urandom),
                     1'($urandom_range(1)));
   endfunction

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == REG_IMAGE_WIDTH) cfg_width = value[WIDTH_REG_W-1:0];
      else if (index == REG_IMAGE_HEIGHT) cfg_height = value;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pixel_backlog.size() != 0 || req_valid || expected_medians.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int w;
      int h;
      int frames;
      int base;
      int group;
      for (int i = 0; i < LINE_DEPTH; i++) begin
         top_line[i] = '0;
         mid_line[i] = '0;
      end
      for (int r = 0; r < KSIZE; r++)
         for (int c = 0; c < KSIZE; c++) win[r][c] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // A small frame with extreme samples, a flush inside the image and
      // padding requests that carry pixel data, all but one without the flush bit.
      write_register(REG_IMAGE_WIDTH, 13'd3);
      write_register(REG_IMAGE_HEIGHT, 13'd2);
      write_register(REG_UNMAPPED, '1);
      queue_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      queue_pixel(8'h55, 8'hAA, 8'h0F, 1'b0);
      queue_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
      queue_pixel(8'hAB, 8'hCD, 8'hEF, 1'b1);
      queue_pixel(8'h80, 8'h7F, 8'h01, 1'b0);
      queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      queue_pixel(8'h12, 8'h34, 8'h56, 1'b0);
      queue_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
      queue_pixel(8'h77, 8'h88, 8'h99, 1'b0);
      drain();

      // Single-column image.
      write_register(REG_IMAGE_WIDTH, 13'd1);
      write_register(REG_IMAGE_HEIGHT, 13'd3);
      queue_pixel(8'hC8, 8'h10, 8'hFF, 1'b0);
      queue_pixel(8'hFF, 8'hFF, 8'h00, 1'b0);
      queue_pixel(8'h01, 8'hFE, 8'h80, 1'b0);
      queue_pixel(8'h55, 8'h55, 8'h55, 1'b0);
      queue_pixel(8'hAA, 8'hAA, 8'hAA, 1'b1);
      drain();

      // A frame cut short, then a narrower width that leaves the position
      // outside the frame, so the next request starts a new one.
      write_register(REG_IMAGE_WIDTH, 13'd4);
      write_register(REG_IMAGE_HEIGHT, 13'd2);
      for (int i = 0; i < 6; i++) queue_pixel(rand_sample(), rand_sample(), rand_sample(), 1'b0);
      drain();
      write_register(REG_IMAGE_WIDTH, 13'd2);
      queue_frame(2, 2);
      drain();

      // Register extremes: zero and values above the largest supported size.
      write_register(REG_IMAGE_WIDTH, 13'd0);
      write_register(REG_IMAGE_HEIGHT, 13'd0);
      queue_frame(1, 1);
      drain();
      write_register(REG_IMAGE_WIDTH, '1);
      write_register(REG_IMAGE_HEIGHT, 13'd1);
      for (int i = 0; i < EXTREME_REQUESTS; i++)
         queue_pixel(rand_sample(), rand_sample(), rand_sample(), 1'b0);
      drain();
      write_register(REG_IMAGE_WIDTH, 13'd1);
      write_register(REG_IMAGE_HEIGHT, '1);
      for (int i = 0; i < EXTREME_REQUESTS; i++)
         queue_pixel(rand_sample(), rand_sample(), rand_sample(), 1'b0);
      drain();

      base = queued_total;
      group = 0;
      while (queued_total - base < RANDOM_REQUESTS || group < 4) begin
         w = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 40);
         h = ($urandom_range(99) < 90) ? $urandom_range(1, 8) : $urandom_range(9, 20);
         if (group == 1) begin
            w = 16;
            h = 12;
         end
         if (group == 3) begin
            w = 24;
            h = 10;
         end
         write_register(REG_IMAGE_WIDTH, CSR_DATA_W'(w));
         write_register(REG_IMAGE_HEIGHT, CSR_DATA_W'(h));
         if (group == 1) hold_wanted <= 1'b1;
         steady <= (group == 3);
         frames = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            if ($urandom_range(9) == 0 && group != 3) begin
               for (int i = $urandom_range(1, w * h + w); i > 0; i--)
                  queue_pixel(rand_sample(), rand_sample(), rand_sample(),
                              $urandom_range(99) < 4);
            end else begin
               queue_frame(w, h);
            end
         end
         drain();
         group++;
      end
      steady <= 1'b0;
      drain();

      if (mismatches == 0 && expected_medians.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
